// ===== design/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and codes for the ring buffer deque
// Operation and status codes, transfer payload types and sequencer states.
// ----------------------------------------------------------------------------
package rbd_pkg;

   localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
   localparam logic [2:0] KIND_POP_BACK   = 3'd1;
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd2;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
   localparam logic [2:0] KIND_REVERSE    = 3'd4;
   localparam logic [2:0] KIND_CLEAR      = 3'd5;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 5;

   typedef struct packed {
      logic [2:0]        kind;
      logic [DATA_W-1:0] data_in;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0]  data_out;
      logic               data_valid;
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REV_RD_A,
      ST_REV_RD_B,
      ST_REV_WR_A,
      ST_REV_WR_B,
      ST_DONE
   } rbd_state_type;

endpackage

// ===== design/ring_buffer_deque_core.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque_core: fixed-capacity double-ended queue
// Circular store with front and rear pointers and an element count, run by a
// small sequencer around one shared wrap-around pointer stepper.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+------------------------------
//   req     | in  | req_valid / req_ready | kind, data_in
//   rsp     | out | rsp_valid / rsp_ready | data_out, data_valid, status, count
//
// Push, pop, clear: the request runs through the execute and final states
// and the result is registered; a new request is taken only back in idle.
// Reverse: swaps floor(count / 2) element pairs, each through the states
// read A, read B, write A, write B on the single read port and single write port.
// Reset clears pointers, count and control; the store is not cleared.
// A result waits in the output register; the sequencer holds in its final
// state only while an earlier result is still not taken.
// ----------------------------------------------------------------------------
module ring_buffer_deque_core #(
   parameter int DEPTH      = 16,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rbd_pkg::req_payload_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rbd_pkg::rsp_payload_type rsp_payload
);
   import rbd_pkg::*;

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HELD_W = $clog2(DEPTH + 1);
   localparam int CPY_W  = (ELEM_WIDTH < DATA_W) ? ELEM_WIDTH : DATA_W;
   localparam int CNT_W  = (HELD_W < COUNT_W) ? HELD_W : COUNT_W;
   localparam logic [PTR_W-1:0]  PtrLast = PTR_W'(DEPTH - 1);
   localparam logic [HELD_W-1:0] HeldFull = HELD_W'(DEPTH);

   rbd_state_type state_ff, state_in;
   logic [2:0]            kind_ff, kind_in;
   logic [ELEM_WIDTH-1:0] elem_ff, elem_in;
   logic [PTR_W-1:0]      front_ff, front_in;
   logic [PTR_W-1:0]      rear_ff, rear_in;
   logic [HELD_W-1:0]     held_ff, held_in;
   logic [PTR_W-1:0]      lo_ff, lo_in;
   logic [PTR_W-1:0]      hi_ff, hi_in;
   logic [HELD_W-1:0]     left_ff, left_in;
   logic [ELEM_WIDTH-1:0] tmp_ff, tmp_in;
   logic                  res_dvalid_ff, res_dvalid_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic [PTR_W-1:0]      step_ptr;
   logic                  step_up;
   logic [PTR_W-1:0]      step_out;

   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic [ELEM_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [PTR_W-1:0]      rd_addr;
   logic [ELEM_WIDTH-1:0] rd_data;

   logic [ELEM_WIDTH-1:0] req_elem;
   logic [DATA_W-1:0]     pop_data;
   logic [COUNT_W-1:0]    count_out;
   logic                  is_full;
   logic                  is_empty;
   logic                  out_free;

   rbd_store #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH),
      .PTR_W      (PTR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared wrap-around pointer stepper
   assign step_out = step_up ? ((step_ptr == PtrLast) ? '0 : step_ptr + 1'b1)
                             : ((step_ptr == '0) ? PtrLast : step_ptr - 1'b1);

   assign is_full  = (held_ff == HeldFull);
   assign is_empty = (held_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      req_elem = '0;
      req_elem[CPY_W-1:0] = req_payload.data_in[CPY_W-1:0];
      pop_data = '0;
      pop_data[CPY_W-1:0] = rd_data[CPY_W-1:0];
      count_out = '0;
      count_out[CNT_W-1:0] = held_ff[CNT_W-1:0];
   end

   always_comb begin
      step_ptr = front_ff;
      step_up  = 1'b1;
      case (state_ff)
         ST_EXEC: begin
            case (kind_ff) inside
               KIND_PUSH_BACK: begin
                  step_ptr = rear_ff;
                  step_up  = 1'b1;
               end
               KIND_POP_BACK, KIND_REVERSE: begin
                  step_ptr = rear_ff;
                  step_up  = 1'b0;
               end
               KIND_PUSH_FRONT: begin
                  step_ptr = front_ff;
                  step_up  = 1'b0;
               end
               default: begin
                  step_ptr = front_ff;
                  step_up  = 1'b1;
               end
            endcase
         end
         ST_REV_WR_A: begin
            step_ptr = lo_ff;
            step_up  = 1'b1;
         end
         ST_REV_WR_B: begin
            step_ptr = hi_ff;
            step_up  = 1'b0;
         end
         default: begin
            step_ptr = front_ff;
            step_up  = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (kind_ff == KIND_REVERSE && held_ff > HELD_W'(1)) begin
               state_in = ST_REV_RD_A;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_REV_RD_A: state_in = ST_REV_RD_B;
         ST_REV_RD_B: state_in = ST_REV_WR_A;
         ST_REV_WR_A: state_in = ST_REV_WR_B;
         ST_REV_WR_B: begin
            state_in = (left_ff == HELD_W'(1)) ? ST_DONE : ST_REV_RD_A;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      kind_in        = kind_ff;
      elem_in        = elem_ff;
      front_in       = front_ff;
      rear_in        = rear_ff;
      held_in        = held_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      left_in        = left_ff;
      tmp_in         = tmp_ff;
      res_dvalid_in  = res_dvalid_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      wr_en          = 1'b0;
      wr_addr        = rear_ff;
      wr_data        = elem_ff;
      rd_en          = 1'b0;
      rd_addr        = front_ff;
      req_ready      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in = req_payload.kind;
               elem_in = req_elem;
            end
         end
         ST_EXEC: begin
            res_status_in = STATUS_OK;
            res_dvalid_in = 1'b0;
            unique case (kind_ff)
               KIND_PUSH_BACK: begin
                  if (is_full) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = rear_ff;
                     rear_in = step_out;
                     held_in = held_ff + 1'b1;
                  end
               end
               KIND_POP_BACK: begin
                  if (is_empty) begin
                     res_status_in = STATUS_EMPTY;
                  end else begin
                     rd_en         = 1'b1;
                     rd_addr       = step_out;
                     rear_in       = step_out;
                     held_in       = held_ff - 1'b1;
                     res_dvalid_in = 1'b1;
                  end
               end
               KIND_PUSH_FRONT: begin
                  if (is_full) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = step_out;
                     front_in = step_out;
                     held_in  = held_ff + 1'b1;
                  end
               end
               KIND_POP_FRONT: begin
                  if (is_empty) begin
                     res_status_in = STATUS_EMPTY;
                  end else begin
                     rd_en         = 1'b1;
                     rd_addr       = front_ff;
                     front_in      = step_out;
                     held_in       = held_ff - 1'b1;
                     res_dvalid_in = 1'b1;
                  end
               end
               KIND_REVERSE: begin
                  lo_in   = front_ff;
                  hi_in   = step_out;
                  left_in = held_ff >> 1;
               end
               KIND_CLEAR: begin
                  held_in  = '0;
                  front_in = '0;
                  rear_in  = '0;
               end
               default: begin
                  res_status_in = STATUS_OK;
               end
            endcase
         end
         ST_REV_RD_A: begin
            rd_en   = 1'b1;
            rd_addr = lo_ff;
         end
         ST_REV_RD_B: begin
            rd_en   = 1'b1;
            rd_addr = hi_ff;
            tmp_in  = rd_data;
         end
         ST_REV_WR_A: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = rd_data;
            lo_in   = step_out;
         end
         ST_REV_WR_B: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = tmp_ff;
            hi_in   = step_out;
            left_in = left_ff - 1'b1;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.data_out   = res_dvalid_ff ? pop_data : '0;
               rsp_payload_in.data_valid = res_dvalid_ff;
               rsp_payload_in.status     = res_status_ff;
               rsp_payload_in.count      = count_out;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         rear_ff      <= '0;
         held_ff      <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         held_ff      <= held_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      elem_ff        <= elem_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      tmp_ff         <= tmp_in;
      res_dvalid_ff  <= res_dvalid_in;
      res_status_ff  <= res_status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTH
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HeldFull)
      else $error("element count beyond capacity");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final state");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && res_dvalid_ff) |-> (res_status_ff == STATUS_OK))
      else $error("popped element flagged with an error status");

   a_walk_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REV_RD_A) |-> (left_ff != '0))
      else $error("reverse walk entered with no swaps left");
`endif

endmodule

// ===== design/rbd_store.sv =====
// ----------------------------------------------------------------------------
// rbd_store: element store of the ring buffer deque
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbd_store #(
   parameter int DEPTH      = 16,
   parameter int ELEM_WIDTH = 32,
   parameter int PTR_W      = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [PTR_W-1:0]      wr_addr,
   input  logic [ELEM_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [PTR_W-1:0]      rd_addr,
   output logic [ELEM_WIDTH-1:0] rd_data
);

   logic [ELEM_WIDTH-1:0] mem [DEPTH];
   logic [ELEM_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/ring_buffer_deque_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_buffer_deque_core_tb: self-checking bench for the ring buffer deque
// A directed table covers the empty and full edges, value extremes, reverse,
// clear and the unused operation codes. It is followed by random traffic that
// alternates between filling, draining and mixed phases. Each result is
// checked against the row's fixed result or else an in-bench deque model,
// with random idle bursts on both channels before a calm tail.
// ----------------------------------------------------------------------------
module ring_buffer_deque_core_tb;
   import rbd_pkg::*;

   localparam int DEPTH        = 16;
   localparam int RANDOM_ITEMS = 1250;
   localparam int CALM_TAIL    = 150;

   localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   typedef struct {
      req_payload_type op;
      bit              fixed;
      rsp_payload_type want;
   } directed_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   logic [31:0] deque_store [DEPTH];
   logic [3:0]  front_idx = '0;
   logic [3:0]  rear_idx = '0;
   logic [4:0]  held_count = '0;

   rsp_payload_type  expected_rsp_q [$];
   directed_row_type directed_rows [$];

   int  mismatch_count = 0;
   int  ops_done = 0;
   int  pops_done = 0;
   int  full_drops = 0;
   int  empty_pops = 0;
   int  reversals = 0;
   int  clears = 0;
   bit  ready_stalls_on = 1'b1;
   int  stall_left = 0;

   ring_buffer_deque_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d results outstanding", expected_rsp_q.size());
      $display("Some tests failed");
      $finish;
   end

   function automatic rsp_payload_type result_of(logic [31:0] value, logic valid,
                                                 logic [1:0] status, logic [4:0] count);
      return {value, valid, status, count};
   endfunction

   function automatic rsp_payload_type deque_step(req_payload_type op);
      rsp_payload_type r;
      logic [31:0]     swap_val;
      logic [3:0]      a;
      logic [3:0]      b;
      int              lo;
      int              hi;
      r = '0;
      ops_done++;
      case (op.kind)
         KIND_PUSH_BACK: begin
            if (held_count == DEPTH) begin
               r.status = STATUS_FULL;
               full_drops++;
            end else begin
               deque_store[rear_idx] = op.data_in;
               rear_idx = rear_idx + 4'd1;
               held_count = held_count + 5'd1;
            end
         end
         KIND_POP_BACK: begin
            if (held_count == 0) begin
               r.status = STATUS_EMPTY;
               empty_pops++;
            end else begin
               rear_idx = rear_idx - 4'd1;
               r.data_out = deque_store[rear_idx];
               r.data_valid = 1'b1;
               held_count = held_count - 5'd1;
               pops_done++;
            end
         end
         KIND_PUSH_FRONT: begin
            if (held_count == DEPTH) begin
               r.status = STATUS_FULL;
               full_drops++;
            end else begin
               front_idx = front_idx - 4'd1;
               deque_store[front_idx] = op.data_in;
               held_count = held_count + 5'd1;
            end
         end
         KIND_POP_FRONT: begin
            if (held_count == 0) begin
               r.status = STATUS_EMPTY;
               empty_pops++;
            end else begin
               r.data_out = deque_store[front_idx];
               r.data_valid = 1'b1;
               front_idx = front_idx + 4'd1;
               held_count = held_count - 5'd1;
               pops_done++;
            end
         end
         KIND_REVERSE: begin
            reversals++;
            lo = 0;
            hi = int'(held_count) - 1;
            while (lo < hi) begin
               a = 4'((int'(front_idx) + lo) % DEPTH);
               b = 4'((int'(front_idx) + hi) % DEPTH);
               swap_val = deque_store[a];
               deque_store[a] = deque_store[b];
               deque_store[b] = swap_val;
               lo++;
               hi--;
            end
         end
         KIND_CLEAR: begin
            clears++;
            held_count = '0;
            front_idx = '0;
            rear_idx = '0;
         end
         default: begin
         end
      endcase
      r.count = held_count;
      return r;
   endfunction

   function automatic logic [31:0] pick_data();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_kind(int mode);
      int roll;
      int push_pct;
      roll = $urandom_range(0, 99);
      push_pct = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 25 : 50;
      if (roll < 2) return ($urandom_range(0, 1) != 0) ? KIND_UNUSED_HI : KIND_UNUSED_LO;
      if (roll < 4) return KIND_CLEAR;
      if (roll < 12) return KIND_REVERSE;
      if ($urandom_range(0, 99) < push_pct)
         return ($urandom_range(0, 1) != 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      return ($urandom_range(0, 1) != 0) ? KIND_POP_FRONT : KIND_POP_BACK;
   endfunction

   function automatic void add_row(logic [2:0] kind, logic [31:0] value, bit fixed,
                                   rsp_payload_type want);
      directed_row_type row;
      row.op.kind = kind;
      row.op.data_in = value;
      row.fixed = fixed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   task automatic send_op(input req_payload_type op, input bit fixed,
                          input rsp_payload_type want, input bit may_idle);
      int              gap;
      rsp_payload_type predicted;
      gap = (may_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= op;
      do @(posedge clock); while (!req_ready);
      predicted = deque_step(op);
      expected_rsp_q.push_back(fixed ? want : predicted);
   endtask

   task automatic note_mismatch(input string what, input rsp_payload_type want,
                                input rsp_payload_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $write("%0t: %s: expected data=%h valid=%b status=%0d count=%0d,",
                $realtime, what, want.data_out, want.data_valid, want.status,
                want.count);
         $display(" got data=%h valid=%b status=%0d count=%0d",
                  got.data_out, got.data_valid, got.status, got.count);
      end
   endtask

   always @(posedge clock) begin
      if (!ready_stalls_on) begin
         stall_left <= 0;
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            note_mismatch("unexpected result", '0, rsp_payload);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_payload.data_out !== want.data_out ||
                rsp_payload.data_valid !== want.data_valid ||
                rsp_payload.status !== want.status ||
                rsp_payload.count !== want.count)
               note_mismatch("result mismatch", want, rsp_payload);
         end
      end
   end

   initial begin : stimulus
      req_payload_type op;
      int              mode;
      int              seg_end;
      bit              idle_on;
      int              i;
      int              n;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(KIND_POP_BACK, 32'h0000_0000, 1, result_of('0, 1'b0, STATUS_EMPTY, 5'd0));
      add_row(KIND_POP_FRONT, 32'hFFFF_FFFF, 1, result_of('0, 1'b0, STATUS_EMPTY, 5'd0));
      add_row(KIND_REVERSE, 32'h0000_0000, 1, result_of('0, 1'b0, STATUS_OK, 5'd0));
      add_row(KIND_UNUSED_HI, 32'hA5A5_A5A5, 1, result_of('0, 1'b0, STATUS_OK, 5'd0));
      for (i = 0; i < DEPTH; i++)
         add_row(i[0] ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                 (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'h0000_0000 : $urandom,
                 1, result_of('0, 1'b0, STATUS_OK, 5'(i + 1)));
      add_row(KIND_PUSH_BACK, 32'h1234_5678, 1, result_of('0, 1'b0, STATUS_FULL, 5'd16));
      add_row(KIND_PUSH_FRONT, 32'h8765_4321, 1, result_of('0, 1'b0, STATUS_FULL, 5'd16));
      add_row(KIND_REVERSE, 32'h0000_0000, 0, '0);
      add_row(KIND_POP_FRONT, 32'h0000_0000, 0, '0);
      add_row(KIND_POP_BACK, 32'h0000_0000, 0, '0);
      add_row(KIND_CLEAR, 32'h0000_0000, 1, result_of('0, 1'b0, STATUS_OK, 5'd0));
      add_row(KIND_POP_BACK, 32'h5A5A_5A5A, 1, result_of('0, 1'b0, STATUS_EMPTY, 5'd0));
      add_row(KIND_UNUSED_LO, 32'hFFFF_FFFF, 1, result_of('0, 1'b0, STATUS_OK, 5'd0));

      foreach (directed_rows[k])
         send_op(directed_rows[k].op, directed_rows[k].fixed, directed_rows[k].want, 1'b1);

      mode = MODE_FILL;
      seg_end = 0;
      idle_on = 1'b1;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == seg_end) begin
            mode = $urandom_range(MODE_FILL, MODE_MIXED);
            idle_on = ($urandom_range(0, 3) != 0);
            seg_end = n + $urandom_range(20, 60);
         end
         if (n >= RANDOM_ITEMS - CALM_TAIL)
            idle_on = 1'b0;
         ready_stalls_on <= idle_on;
         op.kind = pick_kind(mode);
         op.data_in = pick_data();
         send_op(op, 1'b0, '0, idle_on);
      end
      req_valid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Checked %0d operations: %0d pops returned data, %0d pushes dropped when full,",
               ops_done, pops_done, full_drops);
      $display("%0d pops on empty, %0d reversals, %0d clears", empty_pops, reversals, clears);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
